[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk; ASSERT_CLK is disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, also active during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/erld_pkg.sv]
// ----------------------------------------------------------------------------
// erld_pkg
// Shared widths, codes and types for the extent run list decoder.
// ----------------------------------------------------------------------------
package erld_pkg;

  localparam int BYTE_W   = 8;
  localparam int BASE_W   = 64;
  localparam int LEN_W    = 32;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 4;
  localparam int IDX_W    = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_RUN  = 2'd0,
    ST_END  = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] run_byte;
    logic              list_start;
  } in_item_t;

  typedef struct packed {
    logic [BASE_W-1:0] run_start;
    logic [LEN_W-1:0]  run_length;
    status_t           status;
  } result_t;

endpackage

[hw/rtl/erld_in_stage.sv]
// ----------------------------------------------------------------------------
// erld_in_stage
// Input register: captures one byte request per cycle from the stream side while the core takes items.
// ----------------------------------------------------------------------------
module erld_in_stage (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [erld_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] run_byte
  input  logic                         s_tuser,   // [0] list_start
  output logic                         item_valid,
  output erld_pkg::in_item_t           item,
  input  logic                         item_take
);
  import erld_pkg::*;

  logic     valid;
  in_item_t data;

  assign s_tready   = !valid || item_take;
  assign item_valid = valid;
  assign item       = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      valid <= 1'b1;
    end else if (item_take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      data.run_byte   <= s_tdata;
      data.list_start <= s_tuser;
    end
  end

endmodule

[hw/rtl/erld_core.sv]
// ----------------------------------------------------------------------------
// erld_core
// Run list decode state, one byte per cycle while the result register can take, and the result register.
// ----------------------------------------------------------------------------
module erld_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  input  erld_pkg::in_item_t           item,
  output logic                         item_take,
  input  logic [erld_pkg::BASE_W-1:0]  initial_base,
  output logic                         res_valid,
  input  logic                         res_ready,
  output erld_pkg::result_t            res
);
  import erld_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_OFFSET = 2'd2,
    PH_IDLE   = 2'd3
  } phase_t;

  phase_t              phase, phase_next;
  logic [SIZE_W-1:0]   length_size, length_size_next;
  logic [SIZE_W-1:0]   offset_size, offset_size_next;
  logic [IDX_W-1:0]    byte_index, byte_index_next;
  logic [LEN_W-1:0]    length_accum, length_accum_next;
  logic [BASE_W-1:0]   offset_accum, offset_accum_next;
  logic [BASE_W-1:0]   cluster_base, cluster_base_next;
  logic                emit_next;
  result_t             res_next;
  logic                fire;

  assign item_take = !res_valid || res_ready;
  assign fire      = item_valid && item_take;

  always_comb begin
    logic [BYTE_W-1:0] b;
    logic [SIZE_W-1:0] ls, os;
    logic [SIZE_W-1:0] idx_inc;
    logic [BASE_W-1:0] off_full;
    phase_t            ph;
    logic [SIZE_W-1:0] lsz, osz;
    logic [IDX_W-1:0]  idx;
    logic [LEN_W-1:0]  lacc;
    logic [BASE_W-1:0] oacc, base;

    b    = item.run_byte;
    ph   = phase;
    lsz  = length_size;
    osz  = offset_size;
    idx  = byte_index;
    lacc = length_accum;
    oacc = offset_accum;
    base = cluster_base;
    if (item.list_start) begin
      ph   = PH_HEADER;
      lsz  = '0;
      osz  = '0;
      idx  = '0;
      lacc = '0;
      oacc = '0;
      base = initial_base;
    end

    ls      = b[SIZE_W-1:0];
    os      = b[BYTE_W-1:SIZE_W];
    idx_inc = {1'b0, idx} + SIZE_W'(1);
    off_full = oacc | ({{(BASE_W-BYTE_W){1'b0}}, b} << {idx, 3'b000});

    phase_next        = ph;
    length_size_next  = lsz;
    offset_size_next  = osz;
    byte_index_next   = idx;
    length_accum_next = lacc;
    offset_accum_next = oacc;
    cluster_base_next = base;
    emit_next         = 1'b0;
    res_next.run_start  = '0;
    res_next.run_length = '0;
    res_next.status     = ST_RUN;

    case (ph)
      PH_HEADER: begin
        if (b == '0) begin
          phase_next      = PH_IDLE;
          emit_next       = 1'b1;
          res_next.status = ST_END;
        end else if (ls == '0 || ls > SIZE_W'(8) || os > SIZE_W'(8)) begin
          phase_next      = PH_IDLE;
          emit_next       = 1'b1;
          res_next.status = ST_BAD;
        end else begin
          length_size_next  = ls;
          offset_size_next  = os;
          byte_index_next   = '0;
          length_accum_next = '0;
          offset_accum_next = '0;
          phase_next        = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (!idx[2]) begin
          length_accum_next = lacc |
            ({{(LEN_W-BYTE_W){1'b0}}, b} << {idx[1:0], 3'b000});
        end
        if (idx_inc >= lsz) begin
          byte_index_next = '0;
          if (osz == '0) begin
            phase_next          = PH_HEADER;
            emit_next           = 1'b1;
            res_next.run_start  = base;
            res_next.run_length = length_accum_next;
            length_accum_next   = '0;
            offset_accum_next   = '0;
          end else begin
            phase_next = PH_OFFSET;
          end
        end else begin
          byte_index_next = idx_inc[IDX_W-1:0];
        end
      end
      PH_OFFSET: begin
        offset_accum_next = off_full;
        if (idx_inc >= osz) begin
          if (!osz[3] && b[BYTE_W-1]) begin
            off_full = off_full | ({BASE_W{1'b1}} << {osz[2:0], 3'b000});
          end
          cluster_base_next   = base + off_full;
          phase_next          = PH_HEADER;
          byte_index_next     = '0;
          emit_next           = 1'b1;
          res_next.run_start  = cluster_base_next;
          res_next.run_length = lacc;
          length_accum_next   = '0;
          offset_accum_next   = '0;
        end else begin
          byte_index_next = idx_inc[IDX_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      length_size  <= '0;
      offset_size  <= '0;
      byte_index   <= '0;
      length_accum <= '0;
      offset_accum <= '0;
      cluster_base <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (fire) begin
        phase        <= phase_next;
        length_size  <= length_size_next;
        offset_size  <= offset_size_next;
        byte_index   <= byte_index_next;
        length_accum <= length_accum_next;
        offset_accum <= offset_accum_next;
        cluster_base <= cluster_base_next;
      end
      if (item_take) begin
        res_valid <= item_valid && emit_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit_next) begin
      res <= res_next;
    end
  end

  `ASSERT_CLK(a_term_fields_zero,
    (res_valid && res.status != ST_RUN) |-> (res.run_start == '0 && res.run_length == '0),
    "end or error result carries nonzero fields")
  `ASSERT_CLK(a_term_goes_idle,
    (fire && emit_next && res_next.status != ST_RUN) |=> (phase == PH_IDLE),
    "decoder not idle after end or error")
  `ASSERT_CLK(a_idle_silent,
    (fire && phase == PH_IDLE && !item.list_start) |-> !emit_next,
    "result produced while idle")
  `ASSERT_ALWAYS(a_len_index_range,
    (phase == PH_LENGTH) |-> ({1'b0, byte_index} < length_size),
    "length byte index beyond length size")

endmodule

[hw/rtl/extent_run_list_decoder_top.sv]
// ----------------------------------------------------------------------------
// extent_run_list_decoder_top
// A result is loaded into the result register after its last byte passes the input register.
// Throughput: one byte per cycle, limited only by the result register.
// The header, length and offset decode run in one pass per byte.
// Reset (rst, synchronous) clears decode state, cluster base and the initial base register to 0.
// ----------------------------------------------------------------------------
module extent_run_list_decoder_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [erld_pkg::BASE_W-1:0]  cfg_data,   // initial_base
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [erld_pkg::BYTE_W-1:0]  s_tdata,    // [7:0] run_byte
  input  logic                         s_tuser,    // [0] list_start
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [95:0]                  m_tdata,    // [63:0] run_start, [95:64] run_length
  output logic [erld_pkg::STATUS_W-1:0] m_tuser    // [1:0] status
);
  import erld_pkg::*;

  logic              initial_base;
  logic [BASE_W-1:0] base_reg;
  logic              item_valid;
  in_item_t          item;
  logic              item_take;
  result_t           res;

  assign cfg_ready    = 1'b1;
  assign initial_base = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_reg <= '0;
    end else if (initial_base) begin
      base_reg <= cfg_data;
    end
  end

  erld_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  erld_core u_core (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item         (item),
    .item_take    (item_take),
    .initial_base (base_reg),
    .res_valid    (m_tvalid),
    .res_ready    (m_tready),
    .res          (res)
  );

  assign m_tdata = {res.run_length, res.run_start};
  assign m_tuser = res.status;

endmodule

[tb/tb_extent_run_list_decoder_top.sv]
// ----------------------------------------------------------------------------
// tb_extent_run_list_decoder_top
// Stream test of the extent run list decoder. A short table of directed
// bytes (sizes at their limits, sparse runs, end of list, bad sizes, decode
// without list start) is followed by random run lists under several cluster
// bases. A predictor tracks the decode state per accepted byte; results are
// checked in order against it, with random idling on both sides and one long
// receiver hold that backs the block up.
// ----------------------------------------------------------------------------
module tb_extent_run_list_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;
  import erld_pkg::*;

  localparam int ITEMS_PER_PHASE = 215;
  localparam int NUM_PHASES      = 6;
  localparam int DRAIN_CYCLES    = 6;
  localparam int HOLD_CYCLES     = 300;
  localparam int WDOG_LIMIT      = 2000;

  typedef enum logic [1:0] {
    DEC_HEADER, DEC_LENGTH, DEC_OFFSET, DEC_IDLE
  } dec_phase_e;

  typedef struct {
    logic [BYTE_W-1:0] b;
    logic              start;
    bit                typed;
    result_t           res;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [BASE_W-1:0]   cfg_data;
  logic                s_tvalid;
  logic                s_tready;
  logic [BYTE_W-1:0]   s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [95:0]         m_tdata;
  logic [STATUS_W-1:0] m_tuser;

  // sideband that travels with the byte on the request
  bit      pin_typed;
  result_t pin_res;

  // predictor state
  dec_phase_e        dec_phase;
  logic [SIZE_W-1:0] len_size;
  logic [SIZE_W-1:0] off_size;
  logic [IDX_W-1:0]  byte_idx;
  logic [LEN_W-1:0]  len_acc;
  logic [BASE_W-1:0] off_acc;
  logic [BASE_W-1:0] cluster_base;
  logic [BASE_W-1:0] base_reg;

  result_t  run_q[$];
  dir_row_t dir_q[$];
  int       err_cnt;
  int       idle_cnt;
  int       item_cnt;
  bit       burst;
  bit       hold_req;

  extent_run_list_decoder_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #4 clk = ~clk;

  function automatic result_t make_res(input logic [63:0] st, input logic [31:0] len,
                                       input status_t code);
    result_t r;
    r.run_start  = st;
    r.run_length = len;
    r.status     = code;
    return r;
  endfunction

  function automatic result_t close_run();
    result_t r;
    r = make_res(cluster_base, len_acc, ST_RUN);
    dec_phase = DEC_HEADER;
    byte_idx  = '0;
    len_acc   = '0;
    off_acc   = '0;
    return r;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic start,
                                     output result_t r);
    r = '0;
    if (start) begin
      dec_phase    = DEC_HEADER;
      len_size     = '0;
      off_size     = '0;
      byte_idx     = '0;
      len_acc      = '0;
      off_acc      = '0;
      cluster_base = base_reg;
    end
    case (dec_phase)
      DEC_HEADER: begin
        if (b == 8'h00) begin
          dec_phase = DEC_IDLE;
          r = make_res('0, '0, ST_END);
          return 1'b1;
        end
        if (b[3:0] == 4'd0 || b[3:0] > 4'd8 || b[7:4] > 4'd8) begin
          dec_phase = DEC_IDLE;
          r = make_res('0, '0, ST_BAD);
          return 1'b1;
        end
        len_size  = b[3:0];
        off_size  = b[7:4];
        byte_idx  = '0;
        len_acc   = '0;
        off_acc   = '0;
        dec_phase = DEC_LENGTH;
        return 1'b0;
      end
      DEC_LENGTH: begin
        if (byte_idx < 4) len_acc = len_acc | ({24'h0, b} << (8 * byte_idx));
        if (byte_idx + 1 >= len_size) begin
          byte_idx = '0;
          if (off_size == 4'd0) begin
            r = close_run();
            return 1'b1;
          end
          dec_phase = DEC_OFFSET;
          return 1'b0;
        end
        byte_idx = byte_idx + 1'b1;
        return 1'b0;
      end
      DEC_OFFSET: begin
        off_acc = off_acc | ({56'h0, b} << (8 * byte_idx));
        if (byte_idx + 1 >= off_size) begin
          if (off_size < 4'd8 && b[7]) off_acc = off_acc | ({64{1'b1}} << (8 * off_size));
          cluster_base = cluster_base + off_acc;
          r = close_run();
          return 1'b1;
        end
        byte_idx = byte_idx + 1'b1;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_cnt++;
  endtask

  // predict, check and watch for a stall
  always @(posedge clk) begin
    result_t r;
    result_t e;
    bit      got;
    if (rst) begin
      dec_phase    = DEC_HEADER;
      len_size     = '0;
      off_size     = '0;
      byte_idx     = '0;
      len_acc      = '0;
      off_acc      = '0;
      cluster_base = '0;
      base_reg     = '0;
      idle_cnt     = 0;
    end else begin
      if (cfg_valid && cfg_ready) base_reg = cfg_data;
      if (s_tvalid && s_tready) begin
        got = decode_byte(s_tdata, s_tuser, r);
        if (pin_typed) run_q.push_back(pin_res);
        else if (got) run_q.push_back(r);
      end
      if (m_tvalid && m_tready) begin
        if (run_q.size() == 0) begin
          report("result with none pending", m_tdata[63:0], '0);
        end else begin
          e = run_q.pop_front();
          if (m_tdata[63:0] !== e.run_start) report("run_start", m_tdata[63:0], e.run_start);
          if (m_tdata[95:64] !== e.run_length)
            report("run_length", 64'(m_tdata[95:64]), 64'(e.run_length));
          if (m_tuser !== e.status) report("status", 64'(m_tuser), 64'(e.status));
        end
      end
      if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_cnt = 0;
      else
        idle_cnt = idle_cnt + 1;
    end
  end

  initial begin
    do @(posedge clk); while (idle_cnt < WDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stalls, one long hold on request
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = burst ? 0 : $urandom_range(0, 15);
      end
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic start, input bit typed,
                           input result_t res);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tdata   <= b;
    s_tuser   <= start;
    pin_typed <= typed;
    pin_res   <= res;
    do @(posedge clk); while (!s_tready);
    item_cnt++;
  endtask

  task automatic send_rand(input logic [7:0] b, input logic start);
    send_byte(b, start, 1'b0, '0);
  endtask

  task automatic add_row(input logic [7:0] b, input logic start, input bit typed,
                         input logic [63:0] st, input logic [31:0] len, input status_t code);
    dir_row_t row;
    row.b     = b;
    row.start = start;
    row.typed = typed;
    row.res   = make_res(st, len, code);
    dir_q.push_back(row);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (run_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_base(input logic [63:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // one run list: mostly well formed, some cut short, closed badly or random bytes
  task automatic gen_list();
    int       nruns;
    int       ls;
    int       os;
    int       garb;
    bit       first;
    logic [7:0] hdr;
    if ($urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(1, 6)) send_rand(8'($urandom), $urandom_range(0, 3) == 0);
      return;
    end
    nruns = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
    first = 1'b1;
    for (int k = 0; k < nruns; k++) begin
      ls  = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      os  = $urandom_range(0, 8);
      hdr = {os[3:0], ls[3:0]};
      send_rand(hdr, first);
      first = 1'b0;
      if ($urandom_range(0, 14) == 0) begin
        // cut mid-run, next list start must clear it
        repeat ($urandom_range(0, ls + os - 1)) send_rand(8'($urandom), 1'b0);
        return;
      end
      repeat (ls) send_rand(8'($urandom), 1'b0);
      repeat (os) send_rand(8'($urandom), 1'b0);
    end
    case ($urandom_range(0, 9))
      0: send_rand({4'($urandom_range(1, 15)), 4'h0}, first);
      1: send_rand({4'($urandom), 4'($urandom_range(9, 15))}, first);
      2: send_rand({4'($urandom_range(9, 15)), 4'($urandom_range(1, 8))}, first);
      default: send_rand(8'h00, first);
    endcase
    // trailing bytes after the end are ignored and not counted
    garb = $urandom_range(0, 3);
    repeat (garb) send_rand(8'($urandom), 1'b0);
    item_cnt -= garb;
  endtask

  initial begin
    logic [63:0] base_v;
    clk       = 1'b0;
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    m_tready  = 1'b0;
    pin_typed = 1'b0;
    pin_res   = '0;
    err_cnt   = 0;
    item_cnt  = 0;
    burst     = 1'b0;
    hold_req  = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // decode straight from reset, base 0
    add_row(8'h11, 1'b0, 1'b0, '0, '0, ST_RUN);
    add_row(8'h05, 1'b0, 1'b0, '0, '0, ST_RUN);
    add_row(8'h10, 1'b0, 1'b1, 64'h10, 32'h5, ST_RUN);
    // sparse run
    add_row(8'h01, 1'b0, 1'b0, '0, '0, ST_RUN);
    add_row(8'hFF, 1'b0, 1'b1, 64'h10, 32'hFF, ST_RUN);
    add_row(8'h00, 1'b0, 1'b1, '0, '0, ST_END);
    add_row(8'h42, 1'b0, 1'b0, '0, '0, ST_RUN);
    // bad sizes
    add_row(8'h19, 1'b1, 1'b1, '0, '0, ST_BAD);
    add_row(8'hF1, 1'b1, 1'b1, '0, '0, ST_BAD);
    add_row(8'h90, 1'b1, 1'b1, '0, '0, ST_BAD);
    // long length, full 8-byte negative offset
    add_row(8'h85, 1'b1, 1'b0, '0, '0, ST_RUN);
    repeat (4) add_row(8'hFF, 1'b0, 1'b0, '0, '0, ST_RUN);
    add_row(8'h7F, 1'b0, 1'b0, '0, '0, ST_RUN);
    repeat (7) add_row(8'hFF, 1'b0, 1'b0, '0, '0, ST_RUN);
    add_row(8'hFF, 1'b0, 1'b1, {64{1'b1}}, {32{1'b1}}, ST_RUN);
    add_row(8'h00, 1'b0, 1'b1, '0, '0, ST_END);
    foreach (dir_q[i]) send_byte(dir_q[i].b, dir_q[i].start, dir_q[i].typed, dir_q[i].res);

    item_cnt = 0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: base_v = '0;
        1: base_v = {64{1'b1}};
        2: base_v = {$urandom, $urandom};
        3: base_v = 64'h8000_0000_0000_0000;
        4: base_v = {$urandom, $urandom};
        default: base_v = {48'h0, 16'($urandom)};
      endcase
      load_base(base_v);
      burst = (p == 1 || p == 4);
      if (p == 4) hold_req = 1'b1;
      while (item_cnt < (p + 1) * ITEMS_PER_PHASE) gen_list();
    end

    settle();
    if (run_q.size() != 0) report("results never delivered", 64'(run_q.size()), '0);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
